[hw/rtl/shf_pkg.sv]
// ----------------------------------------------------------------------------
// shf_pkg
// Types, constants and mixing functions shared by the hash stream modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shf_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned BC_W   = 3;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // valid byte counts in one beat
  localparam logic [BC_W-1:0] BC_NONE = 3'd0;
  localparam logic [BC_W-1:0] BC_ONE  = 3'd1;
  localparam logic [BC_W-1:0] BC_TWO  = 3'd2;
  localparam logic [BC_W-1:0] BC_THREE = 3'd3;
  localparam logic [BC_W-1:0] BC_FULL = 3'd4;

  typedef struct packed {
    logic [HASH_W-1:0] word;
    logic [BC_W-1:0]   byte_count;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  key_length;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              length_mismatch;
  } out_item_t;

  // one finished key waiting for its avalanche
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              zero_len;
    logic              mismatch;
  } fin_t;

  function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
    sext8 = {{(HASH_W-8){b[7]}}, b};
  endfunction

  function automatic logic [HASH_W-1:0] mix_full(input logic [HASH_W-1:0] h_in,
                                                 input logic [HASH_W-1:0] w);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] t;
    h = h_in + {16'd0, w[15:0]};
    t = ({16'd0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    mix_full = h;
  endfunction

  function automatic logic [HASH_W-1:0] mix_tail(input logic [HASH_W-1:0] h_in,
                                                 input logic [HASH_W-1:0] w,
                                                 input logic [BC_W-1:0]   n);
    logic [HASH_W-1:0] h;
    h = h_in;
    case (n)
      BC_THREE: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      BC_TWO: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      BC_ONE: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: h = h_in;
    endcase
    mix_tail = h;
  endfunction

  // avalanche finish, first half
  function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    aval_a = h;
  endfunction

  // avalanche finish, second half
  function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    aval_b = h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/shf_front.sv]
// ----------------------------------------------------------------------------
// shf_front
// Accepts key beats, keeps the running hash and byte count, and queues one
// finished record per key.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire shf_pkg::in_item_t in_item,
  output logic                  q_push,
  output shf_pkg::fin_t         q_data,
  input  wire logic             q_full
);

  logic [shf_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [shf_pkg::LEN_W-1:0]  seen_r, seen_nxt;
  logic [shf_pkg::LEN_W-1:0]  stated_r, stated_nxt;

  logic                       accept;
  logic [shf_pkg::BC_W-1:0]   n;
  logic [shf_pkg::HASH_W-1:0] hash_base;
  logic [shf_pkg::LEN_W-1:0]  seen_base;
  logic [shf_pkg::LEN_W:0]    seen_sum;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    // saturate counts above a full word
    n = (in_item.byte_count > shf_pkg::BC_FULL) ? shf_pkg::BC_FULL : in_item.byte_count;

    hash_base  = in_item.first ? {1'b0, in_item.key_length} : hash_r;
    seen_base  = in_item.first ? '0 : seen_r;
    stated_nxt = in_item.first ? in_item.key_length : stated_r;

    if (n == shf_pkg::BC_FULL) begin
      hash_nxt = shf_pkg::mix_full(hash_base, in_item.word);
    end else begin
      hash_nxt = shf_pkg::mix_tail(hash_base, in_item.word, n);
    end

    seen_sum = {1'b0, seen_base} + {{(shf_pkg::LEN_W+1-shf_pkg::BC_W){1'b0}}, n};
    seen_nxt = seen_sum[shf_pkg::LEN_W] ? shf_pkg::LEN_MAX : seen_sum[shf_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      seen_r   <= '0;
      stated_r <= '0;
    end else if (accept) begin
      hash_r   <= hash_nxt;
      seen_r   <= seen_nxt;
      stated_r <= stated_nxt;
    end
  end

  assign q_push          = accept && in_item.last;
  assign q_data.hash     = hash_nxt;
  assign q_data.zero_len = (stated_nxt == '0);
  assign q_data.mismatch = (seen_nxt != stated_nxt);

  a_len_first : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.first |=> stated_r == $past(in_item.key_length))
    else $error("stated length not latched on first beat");

  a_seen_no_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_item.first |=> seen_r >= $past(seen_r))
    else $error("byte count decreased within a key");

  a_hold_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> hash_r == $past(hash_r))
    else $error("running hash moved without an accepted beat");

endmodule

`default_nettype wire

[hw/rtl/shf_fifo.sv]
// ----------------------------------------------------------------------------
// shf_fifo
// Short register queue of finished keys between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire shf_pkg::fin_t wr_data,
  output logic               q_full,
  input  wire logic          rd_en,
  output shf_pkg::fin_t      rd_data,
  output logic               q_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  shf_pkg::fin_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !q_full)
    else $error("write to a full queue");

  a_ptr_gap : assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> wr_ptr_r == rd_ptr_r)
    else $error("pointers disagree with empty queue");

endmodule

`default_nettype wire

[hw/rtl/shf_back.sv]
// ----------------------------------------------------------------------------
// shf_back
// Runs the avalanche finish over two stages and holds the result for pop.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire shf_pkg::fin_t  q_data,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output shf_pkg::out_item_t  out_item
);

  logic                       v1_r;
  shf_pkg::fin_t              s1_r;
  logic                       v2_r;
  shf_pkg::out_item_t         s2_r;
  logic                       ld2, ld1;

  // advance stage two when it is free or being popped
  assign ld2   = !v2_r || pop;
  assign ld1   = !v1_r || ld2;
  assign q_pop = ld1 && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= !q_empty;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && !q_empty) begin
      s1_r.hash     <= shf_pkg::aval_a(q_data.hash);
      s1_r.zero_len <= q_data.zero_len;
      s1_r.mismatch <= q_data.mismatch;
    end
    if (ld2 && v1_r) begin
      s2_r.hash_value      <= s1_r.zero_len ? '0 : shf_pkg::aval_b(s1_r.hash);
      s2_r.length_mismatch <= s1_r.mismatch;
    end
  end

  assign empty    = !v2_r;
  assign out_item = s2_r;

  a_hold_stall : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !pop |=> v2_r && $stable(s2_r))
    else $error("result changed while waiting for pop");

  a_s1_drain : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && ld2 |=> v2_r)
    else $error("stage one result lost");

  a_pop_gated : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && ld1)
    else $error("queue read without room");

endmodule

`default_nettype wire

[hw/rtl/superfast_hash_stream.sv]
// ----------------------------------------------------------------------------
// superfast_hash_stream
// Streaming 32-bit SuperFastHash over little-endian key words.
// ----------------------------------------------------------------------------
//  channel  | valid / ready   | payload                        | beat
//  ---------+-----------------+--------------------------------+----------------
//  input    | push / full     | in_item  (shf_pkg::in_item_t)  | one key word
//  result   | !empty / pop    | out_item (shf_pkg::out_item_t) | one hash per key
//
//  One word per cycle while full is low: the running-hash update (add,
//  shift-xor, add) is combinational and registered in the front part.
//  A result passes from its last word through the queue, avalanche stage
//  one and avalanche stage two into the output register.
//  full rises only when FIFO_DEPTH finished keys sit in the queue behind
//  both occupied avalanche stages and a stalled pop.
//  Synchronous reset clears the running hash, byte count and all queues.
// ----------------------------------------------------------------------------
`default_nettype none

module superfast_hash_stream #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire shf_pkg::in_item_t   in_item,
  output logic                     empty,
  input  wire logic                pop,
  output shf_pkg::out_item_t       out_item
);

  logic          q_push, q_full, q_pop, q_empty;
  shf_pkg::fin_t q_wdata, q_rdata;

  shf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  shf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  shf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  a_last_queued : assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_item.last |-> q_push)
    else $error("last beat did not queue a result");

  a_mid_silent : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> push && in_item.last)
    else $error("result queued without a last beat");

  a_full_link : assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !q_empty)
    else $error("full with an empty queue");

endmodule

`default_nettype wire

[tb/superfast_hash_stream_test.sv]
// ----------------------------------------------------------------------------
// superfast_hash_stream_test
// Self-checking bench for the streaming SuperFastHash block. A short table of
// directed key words covers empty keys, the sign-extended tail bytes, byte
// counts above four, partial words mid-key and keys with no opening word.
// Random keys follow, most of them well formed and some of them broken.
// Every hash is checked against a local model of the running hash and byte
// count or a typed row's golden, with random idle push cycles and pop stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module superfast_hash_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1300;

  typedef struct {
    shf_pkg::in_item_t  beat;
    bit                 typed;
    shf_pkg::out_item_t golden;
  } probe_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  shf_pkg::in_item_t  in_beat = '0;
  logic               empty;
  logic               pop = 1'b0;
  shf_pkg::out_item_t out_beat;

  // model of the block's running state
  logic [shf_pkg::HASH_W-1:0] hash_run = '0;
  logic [shf_pkg::LEN_W-1:0]  bytes_run = '0;
  logic [shf_pkg::LEN_W-1:0]  len_run = '0;
  shf_pkg::out_item_t         hashes_due[$];

  int unsigned fail_count = 0;
  int unsigned words_pushed = 0;
  int unsigned hashes_checked = 0;
  int unsigned flags_seen = 0;
  int unsigned empty_keys = 0;

  superfast_hash_stream DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_beat),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("superfast_hash_stream regression: fail");
    $finish;
  end

  function automatic probe_row_t mk_row(input logic [31:0] w, input logic [2:0] bc,
                                        input bit f, input bit l,
                                        input logic [shf_pkg::LEN_W-1:0] klen,
                                        input bit typed,
                                        input logic [31:0] gh, input bit gm);
    probe_row_t r;
    r.beat.word = w;
    r.beat.byte_count = bc;
    r.beat.first = f;
    r.beat.last = l;
    r.beat.key_length = klen;
    r.typed = typed;
    r.golden.hash_value = gh;
    r.golden.length_mismatch = gm;
    return r;
  endfunction

  // Fold one accepted key word into the model; queue the hash on the last one.
  task automatic absorb_word(input shf_pkg::in_item_t b, input bit typed,
                             input shf_pkg::out_item_t golden);
    logic [shf_pkg::HASH_W-1:0] h;
    logic [shf_pkg::HASH_W-1:0] w;
    logic [shf_pkg::HASH_W-1:0] t;
    logic [shf_pkg::BC_W-1:0]   n;
    shf_pkg::out_item_t         due;
    w = b.word;
    n = (b.byte_count > shf_pkg::BC_FULL) ? shf_pkg::BC_FULL : b.byte_count;
    if (b.first) begin
      hash_run = {1'b0, b.key_length};
      bytes_run = '0;
      len_run = b.key_length;
    end
    h = hash_run;
    case (n)
      shf_pkg::BC_FULL: begin
        h += {16'd0, w[15:0]};
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h += h >> 11;
      end
      shf_pkg::BC_THREE: begin
        h += {16'd0, w[15:0]};
        h ^= h << 16;
        h ^= {{24{w[23]}}, w[23:16]} << 18;
        h += h >> 11;
      end
      shf_pkg::BC_TWO: begin
        h += {16'd0, w[15:0]};
        h ^= h << 11;
        h += h >> 17;
      end
      shf_pkg::BC_ONE: begin
        h += {{24{w[7]}}, w[7:0]};
        h ^= h << 10;
        h += h >> 1;
      end
      default: ;
    endcase
    hash_run = h;
    bytes_run = (bytes_run > shf_pkg::LEN_MAX - n) ? shf_pkg::LEN_MAX : bytes_run + n;
    words_pushed++;
    if (b.last) begin
      h ^= h << 3;
      h += h >> 5;
      h ^= h << 4;
      h += h >> 17;
      h ^= h << 25;
      h += h >> 6;
      due.hash_value = (len_run == '0) ? '0 : h;
      due.length_mismatch = (bytes_run != len_run);
      if (typed) due = golden;
      hashes_due.push_back(due);
    end
  endtask

  // Hold push low for gap cycles, then present the beat until it is taken.
  task automatic send_word(input shf_pkg::in_item_t b, input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic hold_for_results();
    push <= 1'b0;
    do @(posedge clk); while (hashes_due.size() != 0);
  endtask

  initial begin : word_side
    probe_row_t        probe_tab[$];
    shf_pkg::in_item_t b;
    int unsigned       len;
    int unsigned       nwords;
    int unsigned       kind;
    int unsigned       keys;
    int unsigned       directed;
    bit                calm;
    // empty keys and keys continued without an opening word
    probe_tab.push_back(mk_row(32'h0, shf_pkg::BC_NONE, 0, 1, shf_pkg::LEN_MAX, 1, 32'h0, 0));
    probe_tab.push_back(mk_row(32'h0, shf_pkg::BC_NONE, 1, 1, 31'd0, 1, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, shf_pkg::BC_FULL, 1, 1, 31'd0, 1, 32'h0, 1));
    probe_tab.push_back(mk_row(32'h1234_5678, shf_pkg::BC_TWO, 0, 1, 31'd9, 1, 32'h0, 1));
    probe_tab.push_back(mk_row(32'hA5A5_5A5A, 3'd7, 1, 1, 31'd0, 1, 32'h0, 1));
    // one, two and three byte tails with the sign bit on and off
    probe_tab.push_back(mk_row(32'h0000_0080, shf_pkg::BC_ONE, 1, 1, 31'd1, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FF7F, shf_pkg::BC_ONE, 1, 1, 31'd1, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, shf_pkg::BC_TWO, 1, 1, 31'd2, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'h00FF_0000, shf_pkg::BC_THREE, 1, 1, 31'd3, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFF7F_FFFF, shf_pkg::BC_THREE, 1, 1, 31'd3, 0, 32'h0, 0));
    // byte counts above four saturate
    probe_tab.push_back(mk_row(32'h0, shf_pkg::BC_FULL, 1, 0, 31'd12, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, 3'd5, 0, 0, 31'd0, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'h1234_5678, 3'd6, 0, 1, shf_pkg::LEN_MAX, 0, 32'h0, 0));
    // partial word in the middle of a key
    probe_tab.push_back(mk_row(32'h0000_00C3, shf_pkg::BC_ONE, 1, 0, 31'd5, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'h89AB_CDEF, shf_pkg::BC_FULL, 0, 1, 31'd0, 0, 32'h0, 0));
    // longest stated length, zero-byte word mid-key
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, shf_pkg::BC_FULL, 1, 0, shf_pkg::LEN_MAX, 0,
                               32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, shf_pkg::BC_NONE, 0, 0, 31'd0, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hFFFF_FFFF, shf_pkg::BC_THREE, 0, 1, 31'd0, 0, 32'h0, 0));
    // word after a finished key keeps the old state
    probe_tab.push_back(mk_row(32'h0, shf_pkg::BC_FULL, 1, 1, 31'd4, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'hDEAD_BEEF, shf_pkg::BC_FULL, 0, 1, 31'd0, 0, 32'h0, 0));
    // a second opening word restarts the key
    probe_tab.push_back(mk_row(32'h8080_8080, shf_pkg::BC_FULL, 1, 0, 31'd7, 0, 32'h0, 0));
    probe_tab.push_back(mk_row(32'h7F80_FF01, shf_pkg::BC_THREE, 1, 1, 31'd7, 0, 32'h0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_tab[i]) begin
      send_word(probe_tab[i].beat, $urandom_range(0, 15));
      absorb_word(probe_tab[i].beat, probe_tab[i].typed, probe_tab[i].golden);
    end
    directed = words_pushed;
    hold_for_results();

    // random keys: kind 0 scrambles byte counts, 1 states a wrong length,
    // 2 drops the opening word, 3 drops the closing word; the rest are clean
    keys = 0;
    while (words_pushed < directed + RANDOM_WORDS) begin
      kind = $urandom_range(0, 11);
      calm = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      nwords = (len == 0) ? 1 : (len + 3) / 4;
      for (int i = 0; i < nwords; i++) begin
        b.word = $urandom;
        if (len == 0)
          b.byte_count = shf_pkg::BC_NONE;
        else if (i == nwords - 1 && len % 4 != 0)
          b.byte_count = 3'(len % 4);
        else
          b.byte_count = shf_pkg::BC_FULL;
        if (kind == 0) b.byte_count = 3'($urandom_range(0, 7));
        b.first = (i == 0) && (kind != 2);
        b.last = (i == nwords - 1) && (kind != 3);
        b.key_length = (i == 0 && kind != 1) ? 31'(len) : 31'($urandom);
        send_word(b, calm ? 0 : $urandom_range(0, 15));
        absorb_word(b, 1'b0, '0);
      end
      keys++;
      if (keys % 97 == 50) hold_for_results();
    end

    hold_for_results();
    repeat (8) @(posedge clk);
    $display("covered %0d key words (%0d directed) in %0d random keys, %0d hashes compared",
             words_pushed, directed, keys, hashes_checked);
    $display("%0d hashes carried a length mismatch, %0d came from an empty stated length",
             flags_seen, empty_keys);
    if (fail_count == 0) begin
      $display("superfast_hash_stream regression: pass");
    end else begin
      $display("superfast_hash_stream regression: fail");
    end
    $finish;
  end

  initial begin : result_side
    shf_pkg::out_item_t want;
    int unsigned        stall;
    bit                 calm;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (hashes_due.size() == 0) begin
        $error("hash_value: no hash expected, got %h", out_beat.hash_value);
        fail_count++;
      end else begin
        want = hashes_due.pop_front();
        hashes_checked++;
        if (want.length_mismatch) flags_seen++;
        if (want.hash_value == '0) empty_keys++;
        if (out_beat.hash_value !== want.hash_value) begin
          $error("hash_value: expected %h, got %h", want.hash_value, out_beat.hash_value);
          fail_count++;
        end
        if (out_beat.length_mismatch !== want.length_mismatch) begin
          $error("length_mismatch: expected %0b, got %0b",
                 want.length_mismatch, out_beat.length_mismatch);
          fail_count++;
        end
      end
    end
  end

endmodule

`default_nettype wire
